FILE: sv/gwp_pkg.sv
// ---------------------------------------------------------------------------
// gwp_pkg
// shared types and codes of the grid wavefront planner
// ---------------------------------------------------------------------------
package gwp_pkg;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [7:0]        col;
    logic [7:0]        row;
    logic signed [7:0] occupancy;
  } gwp_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [14:0] cell_value;
    logic [6:0]  next_col;
    logic [6:0]  next_row;
    logic        reached;
  } gwp_out_t;

  typedef struct packed {
    logic [7:0] width;
    logic [7:0] height;
    logic [3:0] steps;
  } gwp_cfg_t;

  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_BUILD   = 2'd1;
  localparam logic [1:0] OP_READ    = 2'd2;
  localparam logic [1:0] OP_DESCEND = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_ROBOT_OUT = 3'd1;
  localparam logic [2:0] ST_CELL_OUT  = 3'd2;
  localparam logic [2:0] ST_OCCUPIED  = 3'd3;
  localparam logic [2:0] ST_NO_NB     = 3'd4;

  localparam logic [14:0] CV_FREE    = 15'd0;
  localparam logic [14:0] CV_UNKNOWN = 15'd1;
  localparam logic [14:0] CV_OBST    = 15'd2;
  localparam logic [14:0] CV_SEED    = 15'd3;
  localparam logic [14:0] CV_MAX     = 15'd32767;

  localparam logic signed [7:0] OCC_OBST    = 8'sd100;
  localparam logic signed [7:0] OCC_UNKNOWN = -8'sd1;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_STEPS  = 2'd2;

endpackage

FILE: sv/gwp_engine.sv
// ---------------------------------------------------------------------------
// gwp_engine
// grid and queue memories with the sequencer for load, read, build, descend
// ---------------------------------------------------------------------------
module gwp_engine #(
  parameter int GRID_SIDE = 128
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  gwp_pkg::gwp_in_t in_item,
  input  gwp_pkg::gwp_cfg_t cfg,
  output logic             busy,
  output logic             out_valid,
  output gwp_pkg::gwp_out_t out_item
);

  localparam int CW = $clog2(GRID_SIDE);
  localparam int AW = 2 * CW;
  localparam int QW = AW + 1;
  localparam int DEPTH = 1 << AW;
  localparam logic [QW-1:0] Q_ONE = QW'(1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD    = 4'd1;
  localparam logic [3:0] S_DCHK  = 4'd2;
  localparam logic [3:0] S_SEED  = 4'd3;
  localparam logic [3:0] S_ROUND = 4'd4;
  localparam logic [3:0] S_POP   = 4'd5;
  localparam logic [3:0] S_IDX   = 4'd6;
  localparam logic [3:0] S_WVAL  = 4'd7;
  localparam logic [3:0] S_NB    = 4'd8;
  localparam logic [3:0] S_DRAIN = 4'd9;
  localparam logic [3:0] S_MARK  = 4'd10;
  localparam logic [3:0] S_DFIN  = 4'd11;

  localparam logic [1:0] MODE_GROW = 2'd0;
  localparam logic [1:0] MODE_WAVE = 2'd1;
  localparam logic [1:0] MODE_DESC = 2'd2;

  logic [14:0]   grid_mem [DEPTH];
  logic [AW-1:0] queue_mem [DEPTH];

  logic          g_we;
  logic [AW-1:0] g_waddr, g_raddr;
  logic [14:0]   g_wdata, g_rd;
  logic          q_we;
  logic [AW-1:0] q_waddr, q_wdata, q_raddr, q_rd;

  always_ff @(posedge clk) begin
    if (g_we) begin
      grid_mem[g_waddr] <= g_wdata;
    end
    g_rd <= grid_mem[g_raddr];
  end

  always_ff @(posedge clk) begin
    if (q_we) begin
      queue_mem[q_waddr] <= q_wdata;
    end
    q_rd <= queue_mem[q_raddr];
  end

  function automatic logic [AW-1:0] cell_addr(input logic [7:0] c, input logic [7:0] r);
    cell_addr = {CW'(r), CW'(c)};
  endfunction

  function automatic logic [7:0] lo_of(input logic [7:0] p);
    lo_of = (p == 8'd0) ? 8'd0 : p - 8'd1;
  endfunction

  function automatic logic [7:0] hi_of(input logic [7:0] p, input logic [7:0] d);
    hi_of = (({1'b0, p} + 9'd1) < {1'b0, d}) ? p + 8'd1 : p;
  endfunction

  logic [3:0]    state_r, state_nxt;
  logic [1:0]    mode_r, mode_nxt;
  logic [7:0]    w_r, w_nxt, h_r, h_nxt;
  logic [3:0]    steps_r, steps_nxt, round_r, round_nxt;
  logic [7:0]    rc_r, rc_nxt, rr_r, rr_nxt;
  logic          in_map_r, in_map_nxt;
  logic [7:0]    robot_col_r, robot_col_nxt, robot_row_r, robot_row_nxt;
  logic [7:0]    cc_r, cc_nxt, cr_r, cr_nxt;
  logic [7:0]    sc_r, sc_nxt, sr_r, sr_nxt;
  logic          sd_r, sd_nxt;
  logic          pv_r, pv_nxt;
  logic [AW-1:0] pa_r, pa_nxt;
  logic [7:0]    pcol_r, pcol_nxt, prow_r, prow_nxt;
  logic [7:0]    nc_r, nc_nxt, nr_r, nr_nxt;
  logic [7:0]    clast_r, clast_nxt, r0_r, r0_nxt, rlast_r, rlast_nxt;
  logic [14:0]   nv_r, nv_nxt;
  logic [QW-1:0] head_r, head_nxt, tail_r, tail_nxt, end_r, end_nxt;
  logic          found_r, found_nxt;
  logic [15:0]   best_r, best_nxt;
  logic [7:0]    bc_r, bc_nxt, br_r, br_nxt;
  logic [14:0]   bval_r, bval_nxt;
  logic          ov_r, ov_nxt;
  gwp_pkg::gwp_out_t out_r, out_nxt;

  logic        in_map;
  logic [7:0]  ic, ir;
  logic [15:0] cost;

  always_comb begin
    state_nxt = state_r; mode_nxt = mode_r; w_nxt = w_r; h_nxt = h_r;
    steps_nxt = steps_r; round_nxt = round_r; rc_nxt = rc_r; rr_nxt = rr_r;
    in_map_nxt = in_map_r; robot_col_nxt = robot_col_r; robot_row_nxt = robot_row_r;
    cc_nxt = cc_r; cr_nxt = cr_r; sc_nxt = sc_r; sr_nxt = sr_r; sd_nxt = sd_r;
    pv_nxt = pv_r; pa_nxt = pa_r; pcol_nxt = pcol_r; prow_nxt = prow_r;
    nc_nxt = nc_r; nr_nxt = nr_r; clast_nxt = clast_r;
    r0_nxt = r0_r; rlast_nxt = rlast_r; nv_nxt = nv_r;
    head_nxt = head_r; tail_nxt = tail_r; end_nxt = end_r;
    found_nxt = found_r; best_nxt = best_r; bc_nxt = bc_r; br_nxt = br_r;
    bval_nxt = bval_r;
    ov_nxt = 1'b0;
    out_nxt = '0;
    g_we = 1'b0; g_waddr = pa_r; g_wdata = gwp_pkg::CV_OBST; g_raddr = pa_r;
    q_we = 1'b0; q_waddr = tail_r[AW-1:0]; q_wdata = pa_r; q_raddr = head_r[AW-1:0];
    in_map = (in_item.col < cfg.width) && (in_item.row < cfg.height);
    ic = 8'(q_rd[CW-1:0]);
    ir = 8'(q_rd[AW-1:CW]);
    cost = {g_rd, 1'b0} + {15'd0, (pcol_r != cc_r) && (prow_r != cr_r)};

    unique case (state_r) inside
      S_IDLE: begin
        if (start) begin
          g_raddr = cell_addr(in_item.col, in_item.row);
          unique case (in_item.opcode)
            gwp_pkg::OP_LOAD: begin
              ov_nxt = 1'b1;
              if (!in_map) begin
                out_nxt.status = gwp_pkg::ST_CELL_OUT;
              end else begin
                g_we = 1'b1;
                g_waddr = cell_addr(in_item.col, in_item.row);
                g_wdata = (in_item.occupancy == gwp_pkg::OCC_OBST) ? gwp_pkg::CV_OBST :
                          (in_item.occupancy == gwp_pkg::OCC_UNKNOWN) ?
                          gwp_pkg::CV_UNKNOWN : gwp_pkg::CV_FREE;
                out_nxt.cell_value = g_wdata;
              end
            end
            gwp_pkg::OP_READ: begin
              if (!in_map) begin
                ov_nxt = 1'b1;
                out_nxt.status = gwp_pkg::ST_CELL_OUT;
              end else begin
                state_nxt = S_RD;
              end
            end
            gwp_pkg::OP_DESCEND: begin
              if (!in_map) begin
                ov_nxt = 1'b1;
                out_nxt.status = gwp_pkg::ST_CELL_OUT;
              end else begin
                cc_nxt = in_item.col;
                cr_nxt = in_item.row;
                w_nxt = cfg.width;
                h_nxt = cfg.height;
                state_nxt = S_DCHK;
              end
            end
            gwp_pkg::OP_BUILD: begin
              rc_nxt = in_item.col;
              rr_nxt = in_item.row;
              in_map_nxt = in_map;
              w_nxt = cfg.width;
              h_nxt = cfg.height;
              steps_nxt = cfg.steps;
              sc_nxt = 8'd0;
              sr_nxt = 8'd0;
              sd_nxt = 1'b0;
              pv_nxt = 1'b0;
              head_nxt = '0;
              tail_nxt = '0;
              mode_nxt = MODE_GROW;
              state_nxt = S_SEED;
            end
            default: ;
          endcase
        end
      end
      S_RD: begin
        ov_nxt = 1'b1;
        out_nxt.cell_value = g_rd;
        state_nxt = S_IDLE;
      end
      S_DCHK: begin
        if (g_rd == gwp_pkg::CV_OBST) begin
          ov_nxt = 1'b1;
          out_nxt.status = gwp_pkg::ST_OCCUPIED;
          state_nxt = S_IDLE;
        end else begin
          clast_nxt = hi_of(cc_r, w_r);
          r0_nxt = lo_of(cr_r);
          rlast_nxt = hi_of(cr_r, h_r);
          nc_nxt = lo_of(cc_r);
          nr_nxt = lo_of(cr_r);
          found_nxt = 1'b0;
          pv_nxt = 1'b0;
          mode_nxt = MODE_DESC;
          state_nxt = S_NB;
        end
      end
      S_SEED: begin
        if (pv_r && (g_rd == gwp_pkg::CV_OBST)) begin
          q_we = 1'b1;
          tail_nxt = tail_r + Q_ONE;
        end
        if (!sd_r) begin
          g_raddr = cell_addr(sc_r, sr_r);
          pv_nxt = 1'b1;
          pa_nxt = cell_addr(sc_r, sr_r);
          if (sc_r == w_r - 8'd1) begin
            sc_nxt = 8'd0;
            sr_nxt = sr_r + 8'd1;
            sd_nxt = (sr_r == h_r - 8'd1);
          end else begin
            sc_nxt = sc_r + 8'd1;
          end
        end else begin
          pv_nxt = 1'b0;
          if (!pv_r) begin
            round_nxt = 4'd0;
            state_nxt = S_ROUND;
          end
        end
      end
      S_ROUND: begin
        if (round_r == steps_r) begin
          state_nxt = S_MARK;
        end else begin
          end_nxt = tail_r;
          round_nxt = round_r + 4'd1;
          state_nxt = S_POP;
        end
      end
      S_POP: begin
        if (mode_r == MODE_GROW && head_r == end_r) begin
          state_nxt = S_ROUND;
        end else if (mode_r != MODE_GROW && head_r == tail_r) begin
          ov_nxt = 1'b1;
          out_nxt.cell_value = gwp_pkg::CV_SEED;
          state_nxt = S_IDLE;
        end else begin
          head_nxt = head_r + Q_ONE;
          state_nxt = S_IDX;
        end
      end
      S_IDX: begin
        clast_nxt = hi_of(ic, w_r);
        r0_nxt = lo_of(ir);
        rlast_nxt = hi_of(ir, h_r);
        nc_nxt = lo_of(ic);
        nr_nxt = lo_of(ir);
        pv_nxt = 1'b0;
        g_raddr = q_rd;
        state_nxt = (mode_r == MODE_GROW) ? S_NB : S_WVAL;
      end
      S_WVAL: begin
        nv_nxt = (g_rd < gwp_pkg::CV_MAX) ? g_rd + 15'd1 : gwp_pkg::CV_MAX;
        state_nxt = S_NB;
      end
      S_NB, S_DRAIN: begin
        if (pv_r) begin
          case (mode_r)
            MODE_GROW: begin
              if (g_rd <= gwp_pkg::CV_UNKNOWN) begin
                g_we = 1'b1;
                g_wdata = gwp_pkg::CV_OBST;
                q_we = 1'b1;
                tail_nxt = tail_r + Q_ONE;
              end
            end
            MODE_WAVE: begin
              if (g_rd == gwp_pkg::CV_FREE) begin
                g_we = 1'b1;
                g_wdata = nv_r;
                q_we = 1'b1;
                tail_nxt = tail_r + Q_ONE;
              end
            end
            default: begin
              if (g_rd >= gwp_pkg::CV_SEED && (!found_r || cost <= best_r)) begin
                found_nxt = 1'b1;
                best_nxt = cost;
                bc_nxt = pcol_r;
                br_nxt = prow_r;
                bval_nxt = g_rd;
              end
            end
          endcase
        end
        if (state_r == S_NB) begin
          g_raddr = cell_addr(nc_r, nr_r);
          pv_nxt = 1'b1;
          pa_nxt = cell_addr(nc_r, nr_r);
          pcol_nxt = nc_r;
          prow_nxt = nr_r;
          if (nr_r == rlast_r) begin
            nr_nxt = r0_r;
            if (nc_r == clast_r) begin
              state_nxt = S_DRAIN;
            end else begin
              nc_nxt = nc_r + 8'd1;
            end
          end else begin
            nr_nxt = nr_r + 8'd1;
          end
        end else begin
          pv_nxt = 1'b0;
          state_nxt = (mode_r == MODE_DESC) ? S_DFIN : S_POP;
        end
      end
      S_MARK: begin
        if (!in_map_r) begin
          ov_nxt = 1'b1;
          out_nxt.status = gwp_pkg::ST_ROBOT_OUT;
          state_nxt = S_IDLE;
        end else begin
          g_we = 1'b1;
          g_waddr = cell_addr(rc_r, rr_r);
          g_wdata = gwp_pkg::CV_SEED;
          q_we = 1'b1;
          q_waddr = '0;
          q_wdata = cell_addr(rc_r, rr_r);
          robot_col_nxt = rc_r;
          robot_row_nxt = rr_r;
          head_nxt = '0;
          tail_nxt = Q_ONE;
          mode_nxt = MODE_WAVE;
          state_nxt = S_POP;
        end
      end
      S_DFIN: begin
        ov_nxt = 1'b1;
        if (!found_r) begin
          out_nxt.status = gwp_pkg::ST_NO_NB;
        end else begin
          out_nxt.cell_value = bval_r;
          out_nxt.next_col = bc_r[6:0];
          out_nxt.next_row = br_r[6:0];
          out_nxt.reached = (bc_r == robot_col_r) && (br_r == robot_row_r);
        end
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mode_r <= MODE_GROW;
      robot_col_r <= 8'd0;
      robot_row_r <= 8'd0;
      head_r <= '0;
      tail_r <= '0;
      pv_r <= 1'b0;
      sd_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      mode_r <= mode_nxt;
      robot_col_r <= robot_col_nxt;
      robot_row_r <= robot_row_nxt;
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      pv_r <= pv_nxt;
      sd_r <= sd_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_r <= w_nxt; h_r <= h_nxt; steps_r <= steps_nxt; round_r <= round_nxt;
    rc_r <= rc_nxt; rr_r <= rr_nxt; in_map_r <= in_map_nxt;
    cc_r <= cc_nxt; cr_r <= cr_nxt; sc_r <= sc_nxt; sr_r <= sr_nxt;
    pa_r <= pa_nxt; pcol_r <= pcol_nxt; prow_r <= prow_nxt;
    nc_r <= nc_nxt; nr_r <= nr_nxt; clast_r <= clast_nxt;
    r0_r <= r0_nxt; rlast_r <= rlast_nxt; nv_r <= nv_nxt; end_r <= end_nxt;
    found_r <= found_nxt; best_r <= best_nxt; bc_r <= bc_nxt; br_r <= br_nxt;
    bval_r <= bval_nxt; out_r <= out_nxt;
  end

  assign busy = (state_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_item = out_r;

  a_head_le_tail: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= tail_r) else $error("queue head passed tail");

  a_dfin_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DFIN) |=> (out_valid && state_r == S_IDLE))
    else $error("descend ended without a result");

  a_window_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_NB) |-> (nc_r <= clast_r && nr_r <= rlast_r))
    else $error("window walk out of bounds");

  a_wave_queue: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POP && mode_r == MODE_WAVE) |-> (tail_r != '0))
    else $error("wavefront queue lost its seed");

endmodule

FILE: sv/grid_wavefront_planner.sv
// ---------------------------------------------------------------------------
// grid_wavefront_planner
// occupancy grid with obstacle growth, wavefront potentials and descent
//
//   channel  ports                         transaction
//   input    start, busy, in_item          start high while busy low
//   result   out_valid, out_item           one-cycle strobe, no back-pressure
//   config   cfg_we, cfg_index, cfg_data   write when cfg_we high
//
// read and descend are paced by the one grid memory read port
// build scans all w*h cells for seeds, then visits each queued cell
// in every growth round and again in the wavefront
// synchronous reset clears control state; grid contents stay undefined
// the receiver cannot stall; one result per transaction
// ---------------------------------------------------------------------------
module grid_wavefront_planner #(
  parameter int GRID_SIDE = 128
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  gwp_pkg::gwp_in_t  in_item,
  output logic              out_valid,
  output gwp_pkg::gwp_out_t out_item,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_data
);

  logic [7:0] width_r, width_nxt, height_r, height_nxt;
  logic [3:0] steps_r, steps_nxt;
  gwp_pkg::gwp_cfg_t cfg;

  always_comb begin
    width_nxt = width_r;
    height_nxt = height_r;
    steps_nxt = steps_r;
    if (cfg_we) begin
      unique case (cfg_index)
        gwp_pkg::REG_WIDTH:  width_nxt = cfg_data;
        gwp_pkg::REG_HEIGHT: height_nxt = cfg_data;
        gwp_pkg::REG_STEPS:  steps_nxt = cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= 8'd128;
      height_r <= 8'd128;
      steps_r <= 4'd3;
    end else begin
      width_r <= width_nxt;
      height_r <= height_nxt;
      steps_r <= steps_nxt;
    end
  end

  // clamp to 1..GRID_SIDE
  always_comb begin
    cfg.width = (width_r == 8'd0) ? 8'd1 :
                (int'(width_r) > GRID_SIDE) ? 8'(GRID_SIDE) : width_r;
    cfg.height = (height_r == 8'd0) ? 8'd1 :
                 (int'(height_r) > GRID_SIDE) ? 8'(GRID_SIDE) : height_r;
    cfg.steps = steps_r;
  end

  gwp_engine #(.GRID_SIDE(GRID_SIDE)) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start && !busy),
    .in_item   (in_item),
    .cfg       (cfg),
    .busy      (busy),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

FILE: dv/tb_grid_wavefront_planner.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_grid_wavefront_planner
// self-checking bench for the grid wavefront planner: each phase sets the
// map size and growth rounds, loads the whole map, then mixes builds, reads,
// loads and descent walks; a scoreboard class predicts every result
// ---------------------------------------------------------------------------
module tb_grid_wavefront_planner;

  localparam int SIDE       = 128;
  localparam int CYCLE_STOP = 3000000;
  localparam int PEND_DEPTH = 16;

  class plan_scoreboard;
    bit [14:0]   cells [SIDE*SIDE];
    int unsigned work_q [SIDE*SIDE];
    int unsigned map_w = 128, map_h = 128, grow_rounds = 3;
    int unsigned robot_c = 0, robot_r = 0;
    int unsigned walk_c = 0, walk_r = 0;
    gwp_pkg::gwp_out_t pending [PEND_DEPTH];
    int unsigned pend_wr = 0, pend_rd = 0;
    int          errors = 0;

    function int unsigned clamp_dim(int unsigned v);
      return (v < 1) ? 1 : ((v > SIDE) ? SIDE : v);
    endfunction

    function int unsigned outstanding();
      return pend_wr - pend_rd;
    endfunction

    function void write_reg(logic [1:0] idx, logic [7:0] d);
      case (idx)
        gwp_pkg::REG_WIDTH:  map_w = 32'(d);
        gwp_pkg::REG_HEIGHT: map_h = 32'(d);
        gwp_pkg::REG_STEPS:  grow_rounds = 32'(d[3:0]);
        default: ;
      endcase
    endfunction

    function void grow_obstacles(int unsigned w, int unsigned h);
      int unsigned head, tail, stop, idx, pc, pr, c, r, k, c0, c1, r0, r1;
      head = 0;
      tail = 0;
      for (r = 0; r < h; r++)
        for (c = 0; c < w; c++)
          if (cells[r*SIDE+c] == gwp_pkg::CV_OBST) begin
            work_q[tail] = r*SIDE + c;
            tail++;
          end
      for (int unsigned n = 0; n < grow_rounds; n++) begin
        stop = tail;
        while (head < stop) begin
          idx = work_q[head];
          head++;
          pc = idx % SIDE; pr = idx / SIDE;
          c0 = pc > 0 ? pc - 1 : 0; c1 = pc + 2 < w ? pc + 2 : w;
          r0 = pr > 0 ? pr - 1 : 0; r1 = pr + 2 < h ? pr + 2 : h;
          for (c = c0; c < c1; c++)
            for (r = r0; r < r1; r++) begin
              k = r*SIDE + c;
              if (cells[k] <= gwp_pkg::CV_UNKNOWN) begin
                cells[k] = gwp_pkg::CV_OBST;
                if (tail < SIDE*SIDE) begin
                  work_q[tail] = k;
                  tail++;
                end
              end
            end
        end
      end
    endfunction

    function void spread_wave(int unsigned w, int unsigned h, int unsigned sc,
                              int unsigned sr);
      int unsigned head, tail, idx, pc, pr, pv, nv, c, r, k, c0, c1, r0, r1;
      head = 0;
      tail = 0;
      cells[sr*SIDE+sc] = gwp_pkg::CV_SEED;
      work_q[tail] = sr*SIDE + sc;
      tail++;
      while (head < tail) begin
        idx = work_q[head];
        head++;
        pc = idx % SIDE; pr = idx / SIDE;
        pv = 32'(cells[idx]);
        nv = pv < gwp_pkg::CV_MAX ? pv + 1 : 32'(gwp_pkg::CV_MAX);
        c0 = pc > 0 ? pc - 1 : 0; c1 = pc + 2 < w ? pc + 2 : w;
        r0 = pr > 0 ? pr - 1 : 0; r1 = pr + 2 < h ? pr + 2 : h;
        for (c = c0; c < c1; c++)
          for (r = r0; r < r1; r++) begin
            k = r*SIDE + c;
            if (cells[k] == gwp_pkg::CV_FREE) begin
              cells[k] = 15'(nv);
              if (tail < SIDE*SIDE) begin
                work_q[tail] = k;
                tail++;
              end
            end
          end
      end
    endfunction

    function void note_input(gwp_pkg::gwp_in_t it);
      gwp_pkg::gwp_out_t res;
      int unsigned w, h, k, c, r, v, cost, best, bc, br, c0, c1, r0, r1;
      bit          in_map, found;
      res = '0;
      w = clamp_dim(map_w); h = clamp_dim(map_h);
      in_map = (it.col < w) && (it.row < h);
      k = it.row*SIDE + it.col;
      if (it.opcode == gwp_pkg::OP_BUILD) begin
        grow_obstacles(w, h);
        if (!in_map) res.status = gwp_pkg::ST_ROBOT_OUT;
        else begin
          robot_c = 32'(it.col); robot_r = 32'(it.row);
          spread_wave(w, h, 32'(it.col), 32'(it.row));
          res.cell_value = gwp_pkg::CV_SEED;
        end
      end else if (!in_map) begin
        res.status = gwp_pkg::ST_CELL_OUT;
      end else if (it.opcode == gwp_pkg::OP_LOAD) begin
        res.cell_value = (it.occupancy == gwp_pkg::OCC_OBST) ? gwp_pkg::CV_OBST :
                         (it.occupancy == gwp_pkg::OCC_UNKNOWN) ?
                         gwp_pkg::CV_UNKNOWN : gwp_pkg::CV_FREE;
        cells[k] = res.cell_value;
      end else if (it.opcode == gwp_pkg::OP_READ) begin
        res.cell_value = cells[k];
      end else if (cells[k] == gwp_pkg::CV_OBST) begin
        res.status = gwp_pkg::ST_OCCUPIED;
      end else begin
        found = 0; best = 0; bc = 0; br = 0;
        c0 = it.col > 0 ? it.col - 1 : 0; c1 = it.col + 2 < w ? it.col + 2 : w;
        r0 = it.row > 0 ? it.row - 1 : 0; r1 = it.row + 2 < h ? it.row + 2 : h;
        for (c = c0; c < c1; c++)
          for (r = r0; r < r1; r++) begin
            v = 32'(cells[r*SIDE+c]);
            if (v >= gwp_pkg::CV_SEED) begin
              cost = 2*v + ((c != it.col && r != it.row) ? 1 : 0);
              if (!found || cost <= best) begin
                found = 1; best = cost; bc = c; br = r;
              end
            end
          end
        if (!found) res.status = gwp_pkg::ST_NO_NB;
        else begin
          res.cell_value = cells[br*SIDE+bc];
          res.next_col   = 7'(bc);
          res.next_row   = 7'(br);
          res.reached    = (bc == robot_c && br == robot_r);
          walk_c = bc; walk_r = br;
        end
      end
      pending[pend_wr % PEND_DEPTH] = res;
      pend_wr++;
    endfunction

    function void field_diff(string name, int unsigned e, int unsigned a);
      if (e != a) begin
        $display("%0t mismatch %s: expected %0d actual %0d", $time, name, e, a);
        errors++;
      end
    endfunction

    function void check_result(gwp_pkg::gwp_out_t act);
      gwp_pkg::gwp_out_t want;
      if (outstanding() == 0) begin
        $display("%0t unexpected result: expected none actual %h", $time, act);
        errors++;
        return;
      end
      want = pending[pend_rd % PEND_DEPTH];
      pend_rd++;
      if ($isunknown(act)) begin
        $display("%0t unknown bits: expected %h actual %h", $time, want, act);
        errors++;
        return;
      end
      field_diff("status", 32'(want.status), 32'(act.status));
      field_diff("cell_value", 32'(want.cell_value), 32'(act.cell_value));
      field_diff("next_col", 32'(want.next_col), 32'(act.next_col));
      field_diff("next_row", 32'(want.next_row), 32'(act.next_row));
      field_diff("reached", 32'(want.reached), 32'(act.reached));
    endfunction
  endclass

  logic     clk, rst_n, start, busy, out_valid, cfg_we;
  gwp_pkg::gwp_in_t  in_item;
  gwp_pkg::gwp_out_t out_item;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;
  int unsigned cycles = 0;
  int          gap_pct;
  plan_scoreboard sb;

  grid_wavefront_planner i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_STOP) begin
      $display("** grid_wavefront_planner: FAILED **");
      $finish;
    end
    if (rst_n && out_valid === 1'b1) sb.check_result(out_item);
  end

  task automatic issue(logic [1:0] op, logic [7:0] c, logic [7:0] r,
                       logic [7:0] occ);
    gwp_pkg::gwp_in_t it;
    it = {op, c, r, occ};
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    sb.note_input(it);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0 || busy) @(posedge clk);
  endtask

  task automatic set_reg(logic [1:0] idx, logic [7:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.write_reg(idx, d);
  endtask

  function automatic logic [7:0] rand_occ();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 18) return gwp_pkg::OCC_OBST;
    if (p < 28) return gwp_pkg::OCC_UNKNOWN;
    if (p < 70) return 8'd0;
    return 8'($urandom_range(255));
  endfunction

  task automatic run_phase(logic [7:0] w, logic [7:0] h, logic [3:0] rounds,
                           int mode, int n_items);
    int unsigned uw, uh, p, c, r;
    wait_drained();
    set_reg(gwp_pkg::REG_WIDTH, w);
    set_reg(gwp_pkg::REG_HEIGHT, h);
    set_reg(gwp_pkg::REG_STEPS, 8'(rounds));
    gap_pct = (mode == 1) ? 59 : ((mode == 3) ? 22 : 0);
    uw = sb.clamp_dim(32'(w)); uh = sb.clamp_dim(32'(h));
    for (r = 0; r < uh; r++)
      for (c = 0; c < uw; c++) issue(gwp_pkg::OP_LOAD, 8'(c), 8'(r), rand_occ());
    issue(gwp_pkg::OP_BUILD, 8'($urandom_range(uw-1)), 8'($urandom_range(uh-1)),
          8'($urandom_range(255)));
    for (int i = 0; i < n_items; i++) begin
      if (i == n_items/2) wait_drained();
      p = $urandom_range(99);
      if (p < 50) begin
        if ($urandom_range(99) < 60)
          issue(gwp_pkg::OP_DESCEND, 8'(sb.walk_c % uw), 8'(sb.walk_r % uh),
                8'($urandom_range(255)));
        else
          issue(gwp_pkg::OP_DESCEND, 8'($urandom_range(uw-1)), 8'($urandom_range(uh-1)),
                8'($urandom_range(255)));
      end else if (p < 62) begin
        if ($urandom_range(9) == 0)
          issue(gwp_pkg::OP_BUILD, 8'($urandom_range(255)), 8'($urandom_range(255)),
                8'($urandom_range(255)));
        else
          issue(gwp_pkg::OP_BUILD, 8'($urandom_range(uw-1)), 8'($urandom_range(uh-1)),
                8'($urandom_range(255)));
      end else if (p < 80) begin
        if ($urandom_range(7) == 0)
          issue(gwp_pkg::OP_READ, 8'($urandom_range(255)), 8'($urandom_range(255)),
                8'($urandom_range(255)));
        else
          issue(gwp_pkg::OP_READ, 8'($urandom_range(uw-1)), 8'($urandom_range(uh-1)),
                8'($urandom_range(255)));
      end else if (p < 96) begin
        if ($urandom_range(7) == 0)
          issue(gwp_pkg::OP_LOAD, 8'($urandom_range(255)), 8'($urandom_range(255)),
                rand_occ());
        else
          issue(gwp_pkg::OP_LOAD, 8'($urandom_range(uw-1)), 8'($urandom_range(uh-1)),
                rand_occ());
      end else begin
        if ($urandom_range(1))
          issue(gwp_pkg::OP_DESCEND, 8'($urandom_range(255)), 8'($urandom_range(255)),
                8'($urandom_range(255)));
        else
          issue(gwp_pkg::OP_LOAD, 8'($urandom_range(uw-1)), 8'($urandom_range(uh-1)),
                rand_occ());
      end
    end
  endtask

  initial begin
    sb        = new();
    gap_pct   = 0;
    rst_n     = 1'b0;
    start     = 1'b0;
    in_item   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: corners, out-of-map cells, reads and descent on loaded cells
    issue(gwp_pkg::OP_LOAD, 8'd0, 8'd0, gwp_pkg::OCC_OBST);
    issue(gwp_pkg::OP_LOAD, 8'd127, 8'd127, gwp_pkg::OCC_UNKNOWN);
    issue(gwp_pkg::OP_LOAD, 8'd127, 8'd0, 8'd0);
    issue(gwp_pkg::OP_LOAD, 8'd0, 8'd127, 8'd127);
    issue(gwp_pkg::OP_LOAD, 8'd1, 8'd0, 8'h80);
    issue(gwp_pkg::OP_LOAD, 8'd128, 8'd0, gwp_pkg::OCC_OBST);
    issue(gwp_pkg::OP_LOAD, 8'd0, 8'd255, gwp_pkg::OCC_OBST);
    issue(gwp_pkg::OP_READ, 8'd0, 8'd0, 8'd0);
    issue(gwp_pkg::OP_READ, 8'd127, 8'd127, 8'hff);
    issue(gwp_pkg::OP_READ, 8'd1, 8'd0, 8'd0);
    issue(gwp_pkg::OP_READ, 8'd200, 8'd3, 8'd0);
    issue(gwp_pkg::OP_DESCEND, 8'd255, 8'd255, 8'd0);
    issue(gwp_pkg::OP_DESCEND, 8'd0, 8'd0, 8'd0);

    run_phase(8'd5, 8'd4, 4'd1, 0, 50);
    run_phase(8'd0, 8'd0, 4'd0, 1, 20);
    run_phase(8'd12, 8'd12, 4'd15, 2, 55);
    run_phase(8'd255, 8'd1, 4'd2, 3, 35);
    run_phase(8'd1, 8'd128, 4'd3, 0, 35);
    run_phase(8'd9, 8'd7, 4'd0, 1, 60);
    run_phase(8'd6, 8'd11, 4'd4, 3, 60);
    run_phase(8'd128, 8'd2, 4'd1, 2, 35);
    run_phase(8'd8, 8'd8, 4'd2, 0, 60);
    wait_drained();
    repeat (30) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("** grid_wavefront_planner: PASSED **");
    end else begin
      $display("** grid_wavefront_planner: FAILED **");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/gwp_pkg.sv
sv/gwp_engine.sv
sv/grid_wavefront_planner.sv
dv/tb_grid_wavefront_planner.sv
